>>> rtl/core/bb3_pkg.sv
// shared types and constants of the 3x3 rgba box blur
`default_nettype none

package bb3_pkg;

   localparam int CFG_W  = 11;   // size register width
   localparam int ITEM_W = 21;   // items taken in a frame
   localparam int ROW_W  = 12;   // row counter, holds up to two rows past the frame

   localparam logic [CFG_W-1:0] MIN_SIZE     = CFG_W'(2);
   localparam int               WIDTH_RESET  = 640;
   localparam int               HEIGHT_RESET = 480;
   localparam int               MAX_HEIGHT   = 1024;

   localparam int OUTQ_DEPTH = 8;

   // register indexes of the configuration port
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // word kinds on the input channel
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef logic [7:0] chan_type;

   // red sits in the low byte
   typedef struct packed {
      chan_type alpha;
      chan_type blue;
      chan_type green;
      chan_type red;
   } rgba_type;

   // where the centre pixel of a window lies in the frame
   typedef struct packed {
      logic kc_first;
      logic kc_last;
      logic kr_first;
      logic kr_last;
      logic frame_end;
   } pos_type;

   typedef struct packed {
      logic     frame_end;
      rgba_type pix;
   } res_type;

   typedef struct packed {
      logic              done;
      logic [ITEM_W-1:0] quot;
      logic [CFG_W-1:0]  rem;
   } div_res_type;

endpackage

`default_nettype wire

>>> rtl/core/bb3_div.sv
// restoring divider that splits the item count into row and column
`default_nettype none

module bb3_div
   import bb3_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [ITEM_W-1:0] dividend,
   input  wire logic [CFG_W-1:0]  divisor,
   output      logic              busy,
   output      div_res_type       res
);

   localparam int CNT_W = $clog2(ITEM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ITEM_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CFG_W-1:0]  rem_ff;
   logic [CFG_W-1:0]  divisor_ff;
   logic [ITEM_W-1:0] qd_ff;

   logic [CFG_W:0]   shifted;
   logic             q_bit;
   logic [CFG_W-1:0] rem_in;

   // one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, qd_ff[ITEM_W-1]};
      q_bit   = (shifted >= {1'b0, divisor_ff});
      if (q_bit) begin
         rem_in = CFG_W'(shifted - {1'b0, divisor_ff});
      end else begin
         rem_in = shifted[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         qd_ff      <= dividend;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         qd_ff  <= {qd_ff[ITEM_W-2:0], q_bit};
      end
   end

   assign busy     = busy_ff;
   assign res.done = done_ff;
   assign res.quot = qd_ff;
   assign res.rem  = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (busy_ff || done_ff) |-> rem_ff < divisor_ff)
      else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

>>> rtl/core/bb3_lines.sv
// two line stores with read-modify-write and same-address forwarding
`default_nettype none

module bb3_lines
   import bb3_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [AW-1:0] rd_addr,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire rgba_type      wr_px,
   output      rgba_type      up_q,
   output      rgba_type      mid_q
);

   rgba_type up_mem  [DEPTH];
   rgba_type mid_mem [DEPTH];

   rgba_type up_rd_ff;
   rgba_type mid_rd_ff;
   rgba_type fwd_up_ff;
   rgba_type fwd_mid_ff;
   logic     fwd_ff;

   // middle row moves up, new pixel becomes the middle row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         up_mem[wr_addr]  <= mid_q;
         mid_mem[wr_addr] <= wr_px;
      end
      up_rd_ff   <= up_mem[rd_addr];
      mid_rd_ff  <= mid_mem[rd_addr];
      fwd_up_ff  <= mid_q;
      fwd_mid_ff <= wr_px;
   end

   // a read that meets a write to the same entry sees the new word
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign up_q  = fwd_ff ? fwd_up_ff  : up_rd_ff;
   assign mid_q = fwd_ff ? fwd_mid_ff : mid_rd_ff;

endmodule

`default_nettype wire

>>> rtl/core/bb3_win.sv
// 3x3 window, masked channel sums and mean by 4, 6 or 9
`default_nettype none

module bb3_win
   import bb3_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     shift_en,
   input  wire logic     has,
   input  wire pos_type  pos,
   input  wire rgba_type up,
   input  wire rgba_type mid,
   input  wire rgba_type px,
   output      logic     push,
   output      res_type  res
);

   typedef enum logic [1:0] {
      CNT_FOUR,
      CNT_SIX,
      CNT_NINE
   } count_type;

   localparam int SUM_W   = 12;
   localparam int RECIP_W = 13;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int RSH     = 15;
   // ceil(2^15 / n), exact floor for every sum that can occur
   localparam logic [RECIP_W-1:0] RECIP_SIX  = RECIP_W'(5462);
   localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(3641);

   rgba_type win_ff [3][3];

   logic      s2_valid_ff;
   pos_type   s2_pos_ff;

   logic             s3_valid_ff;
   logic [SUM_W-1:0] s3_sum_ff [3];
   count_type        s3_cnt_ff;
   chan_type         s3_alpha_ff;
   logic             s3_fe_ff;

   logic [2:0]       row_ok;
   logic [2:0]       col_ok;
   logic [SUM_W-1:0] sum_in [3];
   count_type        cnt_in;

   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0]  prod [3];
   chan_type           mean [3];

   // window shifts once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (shift_en) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= up;
         win_ff[1][2] <= mid;
         win_ff[2][2] <= px;
      end
   end

   always_comb begin
      row_ok = {!s2_pos_ff.kr_last, 1'b1, !s2_pos_ff.kr_first};
      col_ok = {!s2_pos_ff.kc_last, 1'b1, !s2_pos_ff.kc_first};
      for (int ch = 0; ch < 3; ch++) begin
         sum_in[ch] = '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               if (row_ok[r] && col_ok[c]) begin
                  sum_in[ch] = sum_in[ch] + SUM_W'(win_ff[r][c][8*ch +: 8]);
               end
            end
         end
      end
      if (&row_ok && &col_ok) begin
         cnt_in = CNT_NINE;
      end else if (&row_ok || &col_ok) begin
         cnt_in = CNT_SIX;
      end else begin
         cnt_in = CNT_FOUR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= shift_en && has;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_pos_ff   <= pos;
      s3_sum_ff   <= sum_in;
      s3_cnt_ff   <= cnt_in;
      s3_alpha_ff <= win_ff[1][1].alpha;
      s3_fe_ff    <= s2_pos_ff.frame_end;
   end

   // one multiplier per channel, the output queue registers the product
   always_comb begin
      recip = (s3_cnt_ff == CNT_SIX) ? RECIP_SIX : RECIP_NINE;
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = PROD_W'(s3_sum_ff[ch]) * PROD_W'(recip);
         case (s3_cnt_ff) inside
            CNT_FOUR:           mean[ch] = s3_sum_ff[ch][9:2];
            CNT_SIX, CNT_NINE:  mean[ch] = prod[ch][RSH+7:RSH];
            default:            mean[ch] = '0;
         endcase
      end
   end

   assign push          = s3_valid_ff;
   assign res.frame_end = s3_fe_ff;
   assign res.pix.red   = mean[0];
   assign res.pix.green = mean[1];
   assign res.pix.blue  = mean[2];
   assign res.pix.alpha = s3_alpha_ff;

endmodule

`default_nettype wire

>>> rtl/core/bb3_ofifo.sv
// output queue of blurred words
`default_nettype none

module bb3_ofifo
   import bb3_pkg::*;
#(
   parameter int DEPTH = OUTQ_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire res_type push_data,
   input  wire logic    pop,
   output      logic    not_empty,
   output      res_type head
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   res_type        entry_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff;
   logic [AW-1:0]  rd_ptr_ff;
   logic [CW-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + CW'(1);
            2'b01:   count_ff <= count_ff - CW'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && count_ff == CW'(DEPTH)))
      else $error("output queue overflow");

endmodule

`default_nettype wire

>>> rtl/core/box_blur_3x3_rgba_top.sv
// top level of the streaming 3x3 rgba box blur
//
//   channel  dir  handshake                 payload
//   req      in   req_valid / req_stall     kind, red/green/blue/alpha in
//   rsp      out  rsp_valid / rsp_stall     red/green/blue/alpha out, frame_end
//   csr      in   csr_write_en              csr_index, csr_wdata
//
// one word per cycle while req_stall is low; the result for pixel k leaves on word
// k+width+1 and passes the s1, s2 and s3 registers on its way to the output queue.
// the line stores are read the cycle a word is taken and written the next.
// req_stall rises once eight results are owed, counting those still in the pipe.
// a width write starts a division of the item count, req_stall is high until
// its result is loaded. reset needs no clearing pass over the line stores.
`default_nettype none

module box_blur_3x3_rgba_top
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire logic             req_kind,
   input  wire logic [7:0]       req_red_in,
   input  wire logic [7:0]       req_green_in,
   input  wire logic [7:0]       req_blue_in,
   input  wire logic [7:0]       req_alpha_in,

   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      logic [7:0]       rsp_red_out,
   output      logic [7:0]       rsp_green_out,
   output      logic [7:0]       rsp_blue_out,
   output      logic [7:0]       rsp_alpha_out,
   output      logic             rsp_frame_end,

   input  wire logic             csr_write_en,
   input  wire logic             csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   localparam int AW       = $clog2(MAX_WIDTH);
   localparam int SIZE_TOP = (1 << CFG_W) - 1;
   localparam int W_LIMIT  = (MAX_WIDTH > SIZE_TOP) ? SIZE_TOP : MAX_WIDTH;
   localparam int H_LIMIT  = (MAX_HEIGHT > SIZE_TOP) ? SIZE_TOP : MAX_HEIGHT;
   localparam int W_RESET  = (WIDTH_RESET > W_LIMIT) ? W_LIMIT : WIDTH_RESET;
   localparam int H_RESET  = (HEIGHT_RESET > H_LIMIT) ? H_LIMIT : HEIGHT_RESET;
   localparam int OQ_CW    = $clog2(OUTQ_DEPTH + 1);

   function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int lim);
      if (v < MIN_SIZE) begin
         return MIN_SIZE;
      end else if (int'(v) > lim) begin
         return CFG_W'(lim);
      end
      return v;
   endfunction

   logic [CFG_W-1:0]  w_ff;
   logic [CFG_W-1:0]  h_ff;
   logic [ITEM_W-1:0] item_ff;
   logic [CFG_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic              div_start_ff;
   logic [OQ_CW-1:0]  outstanding_ff;

   logic              s1_valid_ff;
   logic              s1_has_ff;
   pos_type           s1_pos_ff;
   logic [AW-1:0]     s1_addr_ff;
   rgba_type          s1_px_ff;

   logic              accept;
   logic              pop;
   logic              div_busy;
   div_res_type       div_res;

   logic [ROW_W-1:0]  h_ext;
   logic [ROW_W-1:0]  h_p1;
   logic              wrap;
   logic [CFG_W-1:0]  col_e;
   logic [ROW_W-1:0]  row_e;
   logic [ITEM_W-1:0] item_e;
   logic              col_zero;
   logic              has;
   pos_type           pos;
   rgba_type          px;

   logic [CFG_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_in;
   logic [ITEM_W-1:0] item_in;
   logic [ROW_W-1:0]  div_row;

   rgba_type          up_q;
   rgba_type          mid_q;
   logic              push;
   res_type           push_data;
   res_type           head;

   assign req_stall = div_start_ff || div_busy || div_res.done ||
                      (outstanding_ff >= OQ_CW'(OUTQ_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   // position of the incoming word and of the window centre it completes
   always_comb begin
      h_ext    = ROW_W'(h_ff);
      h_p1     = h_ext + ROW_W'(1);
      // a height or width change can leave the count past the last item
      wrap     = (row_ff > h_p1) || ((row_ff == h_p1) && (col_ff != '0));
      col_e    = wrap ? '0 : col_ff;
      row_e    = wrap ? '0 : row_ff;
      item_e   = wrap ? '0 : item_ff;
      col_zero = (col_e == '0);
      has      = (row_e >= ROW_W'(2)) || ((row_e == ROW_W'(1)) && !col_zero);

      // at column zero the centre is the last pixel of the row before
      pos.kc_first  = (col_e == CFG_W'(1));
      pos.kc_last   = col_zero;
      pos.kr_first  = col_zero ? (row_e == ROW_W'(2)) : (row_e == ROW_W'(1));
      pos.kr_last   = col_zero ? (row_e == h_p1) : (row_e == h_ext);
      pos.frame_end = col_zero && (row_e == h_p1);

      if ((req_kind == KIND_PIXEL) && (row_e < h_ext)) begin
         px = {req_alpha_in, req_blue_in, req_green_in, req_red_in};
      end else begin
         px = '0;
      end

      if (pos.frame_end) begin
         col_in  = '0;
         row_in  = '0;
         item_in = '0;
      end else begin
         item_in = item_e + ITEM_W'(1);
         if (col_e + CFG_W'(1) == w_ff) begin
            col_in = '0;
            row_in = row_e + ROW_W'(1);
         end else begin
            col_in = col_e + CFG_W'(1);
            row_in = row_e;
         end
      end

      div_row = (|div_res.quot[ITEM_W-1:ROW_W]) ? '1 : div_res.quot[ROW_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff           <= CFG_W'(W_RESET);
         h_ff           <= CFG_W'(H_RESET);
         item_ff        <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         div_start_ff   <= 1'b0;
         outstanding_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (csr_write_en) begin
            unique case (csr_index)
               REG_WIDTH: begin
                  w_ff         <= clamp_size(csr_wdata, W_LIMIT);
                  div_start_ff <= 1'b1;
               end
               REG_HEIGHT: begin
                  h_ff <= clamp_size(csr_wdata, H_LIMIT);
               end
            endcase
         end

         if (div_res.done) begin
            col_ff <= div_res.rem;
            row_ff <= div_row;
         end else if (accept) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            item_ff <= item_in;
         end

         case ({accept && has, pop})
            2'b10:   outstanding_ff <= outstanding_ff + OQ_CW'(1);
            2'b01:   outstanding_ff <= outstanding_ff - OQ_CW'(1);
            default: outstanding_ff <= outstanding_ff;
         endcase

         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_has_ff  <= has;
      s1_pos_ff  <= pos;
      s1_addr_ff <= AW'(col_e);
      s1_px_ff   <= px;
   end

   bb3_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (item_ff),
      .divisor  (w_ff),
      .busy     (div_busy),
      .res      (div_res)
   );

   bb3_lines #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_lines (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (AW'(col_e)),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_px   (s1_px_ff),
      .up_q    (up_q),
      .mid_q   (mid_q)
   );

   bb3_win u_win (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_valid_ff),
      .has      (s1_has_ff),
      .pos      (s1_pos_ff),
      .up       (up_q),
      .mid      (mid_q),
      .px       (s1_px_ff),
      .push     (push),
      .res      (push_data)
   );

   bb3_ofifo #(
      .DEPTH (OUTQ_DEPTH)
   ) u_ofifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_red_out   = head.pix.red;
   assign rsp_green_out = head.pix.green;
   assign rsp_blue_out  = head.pix.blue;
   assign rsp_alpha_out = head.pix.alpha;
   assign rsp_frame_end = head.frame_end;

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      !(div_start_ff || div_busy || div_res.done) |-> col_ff < w_ff)
      else $error("column count not below image width");

   a_outstanding_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= OQ_CW'(OUTQ_DEPTH))
      else $error("more results outstanding than queue entries");

   a_no_take_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (div_start_ff || div_busy) |=> !s1_valid_ff)
      else $error("word taken while position was being recomputed");

endmodule

`default_nettype wire

>>> tb/sv/box_blur_3x3_rgba_top_test.sv
// self-checking testbench for the streaming 3x3 rgba box blur
`default_nettype none

module box_blur_3x3_rgba_top_test
   import bb3_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LINE_MAX = 1024;

   logic             clock;
   logic             reset        = 1'b1;
   logic             req_valid    = 1'b0;
   logic             req_stall;
   logic             req_kind     = KIND_PIXEL;
   logic [7:0]       req_red_in   = '0;
   logic [7:0]       req_green_in = '0;
   logic [7:0]       req_blue_in  = '0;
   logic [7:0]       req_alpha_in = '0;
   logic             rsp_valid;
   logic             rsp_stall    = 1'b0;
   logic [7:0]       rsp_red_out;
   logic [7:0]       rsp_green_out;
   logic [7:0]       rsp_blue_out;
   logic [7:0]       rsp_alpha_out;
   logic             rsp_frame_end;
   logic             csr_write_en = 1'b0;
   logic             csr_index    = REG_WIDTH;
   logic [CFG_W-1:0] csr_wdata    = '0;

   box_blur_3x3_rgba_top #(.MAX_WIDTH(LINE_MAX)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .req_alpha_in  (req_alpha_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_alpha_out (rsp_alpha_out),
      .rsp_frame_end (rsp_frame_end),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // blur predictor state
   logic [CFG_W-1:0]  cfg_width;
   logic [CFG_W-1:0]  cfg_height;
   rgba_type          upper_line [LINE_MAX];
   rgba_type          middle_line [LINE_MAX];
   rgba_type          blur_win [3][3];
   logic [ITEM_W-1:0] frame_pos;
   res_type           blur_expected[$];

   int unsigned words_in      = 0;
   int unsigned results_seen  = 0;
   int unsigned frames_done   = 0;
   int unsigned mismatch_count = 0;
   int unsigned stall_left    = 0;
   bit          calm_mode     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("box_blur_3x3_rgba_top_test: FAIL");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic rgba_type rand_pix();
      return rgba_type'($urandom);
   endfunction

   function automatic int unsigned size_limit(logic [CFG_W-1:0] v, int unsigned hi);
      if (v < MIN_SIZE) return 2;
      if (v > hi) return hi;
      return v;
   endfunction

   // mean over the in-image part of the window around column cc of the middle row
   function automatic rgba_type window_mean(int unsigned cc, int unsigned row,
                                            int unsigned col, int unsigned w,
                                            int unsigned h);
      int unsigned r0, r1, c0, c1, cnt, sum_r, sum_g, sum_b, i, j;
      rgba_type m;
      r0 = (row > 0) ? 0 : 1;
      r1 = (row + 1 < h) ? 2 : 1;
      c0 = (col > 0 && cc > 0) ? cc - 1 : cc;
      c1 = (col + 1 < w && cc < 2) ? cc + 1 : cc;
      cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (i = r0; i <= r1; i++) begin
         for (j = c0; j <= c1; j++) begin
            sum_r += blur_win[i][j].red;
            sum_g += blur_win[i][j].green;
            sum_b += blur_win[i][j].blue;
         end
      end
      m.red   = 8'(sum_r / cnt);
      m.green = 8'(sum_g / cnt);
      m.blue  = 8'(sum_b / cnt);
      m.alpha = blur_win[1][cc].alpha;
      return m;
   endfunction

   task automatic predict_word(input logic kind, input rgba_type pix_in);
      int unsigned w, h, total, last, t, c, k, i;
      rgba_type px, up_px, mid_px;
      res_type res;
      logic has;
      w = size_limit(cfg_width, LINE_MAX);
      h = size_limit(cfg_height, MAX_HEIGHT);
      total = w * h;
      last = total + w;
      // a size change can leave the count beyond the new frame
      if (frame_pos > last) frame_pos = '0;
      t = frame_pos;
      c = t % w;
      px = (kind == KIND_PIXEL && t < total) ? pix_in : '0;
      has = (t >= w + 1);
      k = has ? t - w - 1 : 0;
      res = '0;
      // on the first column the centre is still the newest window column
      if (has && c == 0) res.pix = window_mean(2, k / w, k % w, w, h);
      up_px = upper_line[c];
      mid_px = middle_line[c];
      upper_line[c] = mid_px;
      middle_line[c] = px;
      for (i = 0; i < 3; i++) begin
         blur_win[i][0] = blur_win[i][1];
         blur_win[i][1] = blur_win[i][2];
      end
      blur_win[0][2] = up_px;
      blur_win[1][2] = mid_px;
      blur_win[2][2] = px;
      if (has && c != 0) res.pix = window_mean(1, k / w, k % w, w, h);
      frame_pos = ITEM_W'(t + 1);
      if (has) begin
         res.frame_end = (k + 1 == total);
         blur_expected.push_back(res);
         if (res.frame_end) begin
            frame_pos = '0;
            frames_done++;
         end
      end
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_word(input logic kind, input rgba_type pix);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_red_in   <= pix.red;
      req_green_in <= pix.green;
      req_blue_in  <= pix.blue;
      req_alpha_in <= pix.alpha;
      do @(posedge clock); while (req_stall);
      words_in++;
      predict_word(kind, pix);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (blur_expected.size() != 0) @(negedge clock);
   endtask

   task automatic write_size_reg(input logic idx, input logic [CFG_W-1:0] value);
      drain_results();
      // pipeline tail and any width division settle first
      repeat (30) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == REG_WIDTH) cfg_width = value;
      else cfg_height = value;
   endtask

   // send words until the current frame has given its last result
   task automatic finish_frame(input int unsigned noise_pct);
      int unsigned total;
      logic kind;
      total = size_limit(cfg_width, LINE_MAX) * size_limit(cfg_height, MAX_HEIGHT);
      do begin
         kind = (frame_pos < total) ? KIND_PIXEL : KIND_FLUSH;
         if ($urandom_range(0, 99) < noise_pct) kind = ~kind;
         if (noise_pct != 0 && $urandom_range(0, 199) == 0) drain_results();
         send_word(kind, rand_pix());
      end while (frame_pos != 0);
   endtask

   task automatic test_corner_values();
      write_size_reg(REG_WIDTH, CFG_W'(3));
      write_size_reg(REG_HEIGHT, CFG_W'(3));
      // 3x3 frame: nine neighbours at the centre, six on edges, four at corners
      send_word(KIND_PIXEL, 32'hffffffff);
      send_word(KIND_PIXEL, 32'h00000000);
      send_word(KIND_PIXEL, 32'h7f01fe80);
      send_word(KIND_PIXEL, 32'h01020304);
      send_word(KIND_PIXEL, 32'hfefdfcfb);
      send_word(KIND_PIXEL, 32'h80808080);
      send_word(KIND_PIXEL, 32'h00ff00ff);
      send_word(KIND_PIXEL, 32'hff00ff00);
      send_word(KIND_PIXEL, 32'h12345678);
      repeat (4) send_word(KIND_FLUSH, 32'h00000000);
      write_size_reg(REG_HEIGHT, CFG_W'(2));
      // flush in a pixel slot enters as black, pixels in flush slots are dropped
      send_word(KIND_PIXEL, 32'hffffffff);
      send_word(KIND_PIXEL, 32'hfffefdfc);
      send_word(KIND_FLUSH, 32'hffffffff);
      send_word(KIND_PIXEL, 32'h00000001);
      send_word(KIND_PIXEL, 32'ha5a5a5a5);
      send_word(KIND_PIXEL, 32'h5a5a5a5a);
      send_word(KIND_PIXEL, 32'h13579bdf);
      send_word(KIND_PIXEL, 32'h2468ace0);
      send_word(KIND_PIXEL, 32'hffffffff);
      send_word(KIND_PIXEL, 32'h0f0f0f0f);
   endtask

   task automatic test_mid_frame_change();
      write_size_reg(REG_WIDTH, CFG_W'(8));
      write_size_reg(REG_HEIGHT, CFG_W'(4));
      finish_frame(0);
      // narrower rows, count still inside the frame
      repeat (5) send_word(KIND_PIXEL, rand_pix());
      write_size_reg(REG_WIDTH, CFG_W'(4));
      finish_frame(0);
      // shorter frame, count already past its end
      repeat (14) send_word(KIND_PIXEL, rand_pix());
      write_size_reg(REG_HEIGHT, CFG_W'(2));
      finish_frame(0);
      // taller frame after the flush slots have begun
      repeat (10) send_word((frame_pos < 8) ? KIND_PIXEL : KIND_FLUSH, rand_pix());
      write_size_reg(REG_HEIGHT, CFG_W'(4));
      finish_frame(0);
      write_size_reg(REG_WIDTH, CFG_W'(2));
      finish_frame(0);
   endtask

   task automatic test_random_frames();
      int unsigned first_word;
      first_word = words_in;
      while (words_in - first_word < 500) begin
         calm_mode = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 11) == 0) begin
               write_size_reg(REG_WIDTH, CFG_W'($urandom_range(11, 32)));
               write_size_reg(REG_HEIGHT, CFG_W'($urandom_range(2, 8)));
            end else begin
               // 0 and 1 saturate to 2
               write_size_reg(REG_WIDTH, CFG_W'($urandom_range(0, 10)));
               write_size_reg(REG_HEIGHT, CFG_W'($urandom_range(0, 6)));
            end
         end
         finish_frame(4);
      end
      calm_mode = 1'b0;
   endtask

   task automatic test_size_extremes();
      // oversized writes saturate to 1024 wide and 1024 tall
      write_size_reg(REG_WIDTH, CFG_W'(2047));
      write_size_reg(REG_HEIGHT, CFG_W'(1));
      repeat (30) send_word(KIND_PIXEL, rand_pix());
      write_size_reg(REG_HEIGHT, CFG_W'(2047));
      repeat (10) send_word(KIND_PIXEL, rand_pix());
      // width 2 puts the count deep inside a tall frame
      write_size_reg(REG_WIDTH, CFG_W'(0));
      repeat (6) send_word(KIND_PIXEL, rand_pix());
      // height 2 leaves the count past the frame end
      write_size_reg(REG_HEIGHT, CFG_W'(1));
      finish_frame(0);
   endtask

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   task automatic report_field(input string field, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         if (mismatch_count < 10)
            $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_words
      res_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (blur_expected.size() == 0) begin
            if (mismatch_count < 10)
               $display("result %0d arrived with nothing expected", results_seen);
            mismatch_count++;
         end else begin
            want = blur_expected.pop_front();
            report_field("red_out", want.pix.red, rsp_red_out);
            report_field("green_out", want.pix.green, rsp_green_out);
            report_field("blue_out", want.pix.blue, rsp_blue_out);
            report_field("alpha_out", want.pix.alpha, rsp_alpha_out);
            report_field("frame_end", want.frame_end, rsp_frame_end);
         end
         results_seen++;
      end
   end

   initial begin : main_seq
      int unsigned guard, i, j;
      cfg_width = CFG_W'(WIDTH_RESET);
      cfg_height = CFG_W'(HEIGHT_RESET);
      frame_pos = '0;
      for (i = 0; i < LINE_MAX; i++) begin
         upper_line[i] = '0;
         middle_line[i] = '0;
      end
      for (i = 0; i < 3; i++)
         for (j = 0; j < 3; j++)
            blur_win[i][j] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_values();
      test_mid_frame_change();
      test_random_frames();
      test_size_extremes();

      req_valid <= 1'b0;
      guard = 0;
      while (blur_expected.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (blur_expected.size() != 0) begin
         $display("%0d expected results never arrived", blur_expected.size());
         mismatch_count += blur_expected.size();
      end
      $display("sent %0d words, checked %0d results over %0d completed frames",
               words_in, results_seen, frames_done);
      $display("frames from 2x2 to 32x8, saturated size writes at both ends, mid-frame changes");
      if (mismatch_count == 0) begin
         $display("box_blur_3x3_rgba_top_test: PASS");
      end else begin
         $display("box_blur_3x3_rgba_top_test: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> box_blur_3x3_rgba_top.f
rtl/core/bb3_pkg.sv
rtl/core/bb3_div.sv
rtl/core/bb3_lines.sv
rtl/core/bb3_win.sv
rtl/core/bb3_ofifo.sv
rtl/core/box_blur_3x3_rgba_top.sv
tb/sv/box_blur_3x3_rgba_top_test.sv
